// ===== rtl/brcsc_pkg.sv =====
// Shared types and constants for the binary range coder size counter.
// Used by brcsc_ctrl, brcsc_datapath and the top level; no dependencies.
package brcsc_pkg;

  localparam int unsigned CountW  = 48;
  localparam int unsigned StepW   = 3;
  localparam int unsigned ProbW   = 16;
  localparam int unsigned IntW    = 32;
  localparam int unsigned NormMax = 4;

  localparam logic [CountW-1:0] CountMax   = 48'hffff_ffff_ffff;
  localparam logic [IntW-1:0]   LowReset   = 32'h0000_0000;
  localparam logic [IntW-1:0]   HighReset  = 32'hffff_ffff;
  localparam logic [7:0]        HighFill   = 8'hff;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic             bit_value;
    logic [ProbW-1:0] probability;
  } in_beat_t;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [StepW-1:0]  bytes_this_step;
    logic              stream_done;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic mul;
    logic split;
    logic norm_step;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_equal;
    logic shift_full;
    logic finish;
  } dp_status_t;

endpackage

// ===== rtl/binary_range_coder_size_counter_top.sv =====
// Top level of the binary range coder size counter.
// Instantiates brcsc_ctrl and brcsc_datapath; uses brcsc_pkg.
//
// Counts the bytes a carry-less 32-bit binary arithmetic coder would emit.
// Each input beat is either an encode (bit plus 16-bit probability) or a
// finish; every beat yields exactly one result beat carrying the saturating
// 48-bit total, the bytes added by that beat and a done flag. After a finish
// the interval and count return to their reset values. One beat is in work at
// a time: an encode passes through the 16x16 split multiply, the split add,
// one byte shift per matching top byte up to four plus the check, then the
// result load; a finish skips the multiply and split. The next beat is
// accepted in the cycle after the result load. The result sits in an output
// register, so the next beat is taken while a result still waits on the
// output; that beat then holds at the result load until the waiting result
// is taken.
module binary_range_coder_size_counter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  brcsc_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output brcsc_pkg::out_beat_t out_data_o
);

  brcsc_pkg::dp_cmd_t    dp_cmd;
  brcsc_pkg::dp_status_t dp_status;

  brcsc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_command_i (in_data_i.command),
    .cmd_o        (dp_cmd),
    .status_i     (dp_status)
  );

  brcsc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/brcsc_datapath.sv =====
// Interval registers, split multiplier, byte normalizer and saturating counter.
// Driven by brcsc_ctrl through brcsc_pkg::dp_cmd_t; uses brcsc_pkg.
module brcsc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brcsc_pkg::dp_cmd_t    cmd_i,
  output brcsc_pkg::dp_status_t status_o,
  input  brcsc_pkg::in_beat_t   in_data_i,
  output brcsc_pkg::out_beat_t  out_data_o
);

  logic [brcsc_pkg::IntW-1:0]   low_q, low_d, high_q, high_d;
  logic [brcsc_pkg::CountW-1:0] total_q, total_d, sat_total;
  logic [brcsc_pkg::CountW:0]   sum;
  logic [brcsc_pkg::StepW-1:0]  shift_q, shift_d, produced;
  logic [brcsc_pkg::IntW-1:0]   range_w, split_w;
  logic [brcsc_pkg::IntW-1:0]   prod_hi_q, prod_lo_q;
  brcsc_pkg::in_beat_t          item_q;
  brcsc_pkg::out_beat_t         out_q, out_d;
  logic                         finish;

  assign finish   = (item_q.command == brcsc_pkg::CMD_FINISH);
  assign range_w  = high_q - low_q;
  assign split_w  = low_q + prod_hi_q + {16'd0, prod_lo_q[31:16]};
  assign produced = shift_q + {2'd0, finish};
  assign sum      = {1'b0, total_q} + {{(brcsc_pkg::CountW-2){1'b0}}, produced};
  assign sat_total = (sum > {1'b0, brcsc_pkg::CountMax}) ? brcsc_pkg::CountMax
                                                         : sum[brcsc_pkg::CountW-1:0];

  assign status_o.top_equal  = (low_q[31:24] == high_q[31:24]);
  assign status_o.shift_full = (shift_q == brcsc_pkg::StepW'(brcsc_pkg::NormMax));
  assign status_o.finish     = finish;

  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    total_d = total_q;
    shift_d = shift_q;
    if (cmd_i.load_item) begin
      shift_d = '0;
    end
    if (cmd_i.split) begin
      if (item_q.bit_value) begin
        high_d = split_w;
      end else begin
        low_d = split_w + 32'd1;
      end
    end
    if (cmd_i.norm_step) begin
      low_d   = {low_q[23:0], 8'd0};
      high_d  = {high_q[23:0], brcsc_pkg::HighFill};
      shift_d = shift_q + 3'd1;
    end
    if (cmd_i.load_out) begin
      total_d = sat_total;
      if (finish) begin
        low_d   = brcsc_pkg::LowReset;
        high_d  = brcsc_pkg::HighReset;
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= brcsc_pkg::LowReset;
      high_q  <= brcsc_pkg::HighReset;
      total_q <= '0;
      shift_q <= '0;
    end else begin
      low_q   <= low_d;
      high_q  <= high_d;
      total_q <= total_d;
      shift_q <= shift_d;
    end
  end

  always_comb begin
    out_d.byte_count      = sat_total;
    out_d.bytes_this_step = produced;
    out_d.stream_done     = finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_hi_q <= range_w[31:16] * item_q.probability;
      prod_lo_q <= range_w[15:0] * item_q.probability;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  a_shift_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.norm_step |-> (status_o.top_equal && !status_o.shift_full))
    else $error("byte shift issued without matching top bytes");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q <= brcsc_pkg::StepW'(brcsc_pkg::NormMax))
    else $error("normalization ran past four shifts");

  a_finish_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && finish) |=>
      (low_q == brcsc_pkg::LowReset && high_q == brcsc_pkg::HighReset && total_q == '0))
    else $error("coder not returned to reset interval after finish");

endmodule

// ===== rtl/brcsc_ctrl.sv =====
// Sequencer for the coder: accept, multiply, split, normalize, emit.
// Holds the output valid flag; commands brcsc_datapath. Uses brcsc_pkg.
module brcsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  brcsc_pkg::cmd_e       in_command_i,
  output brcsc_pkg::dp_cmd_t    cmd_o,
  input  brcsc_pkg::dp_status_t status_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SPLIT = 5'b00100,
    S_NORM  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = (in_command_i == brcsc_pkg::CMD_FINISH) ? S_NORM : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SPLIT;
      end
      S_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = S_NORM;
      end
      S_NORM: begin
        if (status_i.top_equal && !status_i.shift_full) begin
          cmd_o.norm_step = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("result emitted over an untaken result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped before it was taken");

endmodule
